// File: rtl/core/uer_pkg.sv
// Shared constants, codes and types for the ultrasonic echo ranger.
// Used by the sequencer, the distance stage and the top level.
package uer_pkg;

	localparam int CHANNEL_COUNT   = 3;
	localparam int TRIGGER_TICKS   = 10;
	localparam int MIN_ECHO_TICKS  = 100;
	localparam int MAX_ECHO_TICKS  = 25000;
	localparam int ECHO_WAIT_TICKS = 30000;
	localparam int TRIG_LOW_TICKS  = 2;
	localparam int CM_DIVISOR      = 58;
	localparam int MIN_VALID_CM    = 2;

	// field widths
	localparam int ECHO_W  = 3;
	localparam int CH_W    = 2;
	localparam int LIMIT_W = 9;
	localparam int GAP_W   = 20;
	localparam int DIST_W  = 10;
	localparam int CNT_W   = GAP_W;
	localparam int CFG_W   = GAP_W;
	localparam int IDX_W   = 2;

	// pulse length and its quotient by the divisor
	localparam int LEN_W  = $clog2(MAX_ECHO_TICKS + 1);
	localparam int QUOT_W = $clog2(MAX_ECHO_TICKS / CM_DIVISOR + 1);
	localparam int CMP_W  = (QUOT_W > LIMIT_W) ? QUOT_W : LIMIT_W;

	// length / 58 as a multiply by a rounded-up reciprocal, exact for LEN_W bits
	localparam int DIV_SHIFT = LEN_W + 7;
	localparam int RECIP_W   = DIV_SHIFT - 5;
	localparam logic [RECIP_W-1:0] CM_RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CM_DIVISOR) - 64'd1) / 64'(CM_DIVISOR));
	localparam int PROD_W = LEN_W + RECIP_W;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_RUN_ENABLE  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_RANGE_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] CFG_CHANNEL_GAP = 2'd2;

	typedef enum logic [1:0] {
		RES_TIMEOUT,
		RES_FAULT,
		RES_PULSE
	} uer_kind_t;

	// one tick's outcome from the sequencer
	typedef struct packed {
		logic [ECHO_W-1:0] trig;
		logic              ready;
		logic [CH_W-1:0]   channel;
		uer_kind_t         kind;
		logic [LEN_W-1:0]  len;
		logic              last;
	} uer_meas_t;

endpackage

// File: rtl/core/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger: one tick word in, one result word out.
// A word accepted into the input register passes the sequencer register, then the output register (out_valid).
// Throughput: one word per cycle while out_ready does not stall the output; the sequencer state updates once per tick.
// Reset (arst_n low, asynchronous): idle, channel 0, counter cleared, pipeline empty,
// registers run_enable 0, range_limit_cm 400, channel_gap_us 20000.
// Depends on uer_pkg, uer_seq and uer_dist.
module ultrasonic_echo_ranger_top import uer_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ECHO_W-1:0]  echo_levels,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ECHO_W-1:0]  trigger_levels,
	output logic               reading_ready,
	output logic [CH_W-1:0]    reading_channel,
	output logic signed [DIST_W-1:0] range_cm,
	output logic               reading_valid,
	output logic               round_done
);

	logic               run_enable_q;
	logic [LIMIT_W-1:0] range_limit_q;
	logic [GAP_W-1:0]   gap_q;
	logic               valid_s1;
	logic [ECHO_W-1:0]  echo_s1;
	logic               valid_s2;
	uer_meas_t          meas_s2;
	logic               load_s2;
	logic               fire;

	assign fire     = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q  <= 1'b0;
			range_limit_q <= LIMIT_W'(400);
			gap_q         <= GAP_W'(20000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RUN_ENABLE:  run_enable_q  <= cfg_data[0];
				CFG_RANGE_LIMIT: range_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_CHANNEL_GAP: gap_q         <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			echo_s1 <= echo_levels;
		end
	end

	uer_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.run_enable     (run_enable_q),
		.channel_gap_us (gap_q),
		.fire           (fire),
		.echo_s1        (echo_s1),
		.load_s2        (load_s2),
		.valid_s2       (valid_s2),
		.meas_s2        (meas_s2)
	);

	uer_dist u_dist (
		.clk             (clk),
		.arst_n          (arst_n),
		.range_limit_cm  (range_limit_q),
		.valid_s2        (valid_s2),
		.meas_s2         (meas_s2),
		.load_s2         (load_s2),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.trigger_levels  (trigger_levels),
		.reading_ready   (reading_ready),
		.reading_channel (reading_channel),
		.range_cm        (range_cm),
		.reading_valid   (reading_valid),
		.round_done      (round_done)
	);

endmodule

// File: rtl/core/uer_seq.sv
// Measurement sequencer: phase, active channel and tick counter; one word per tick.
// Depends on uer_pkg.
module uer_seq import uer_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run_enable,
	input  logic [GAP_W-1:0] channel_gap_us,
	input  logic             fire,
	input  logic [ECHO_W-1:0] echo_s1,
	input  logic             load_s2,
	output logic             valid_s2,
	output uer_meas_t        meas_s2
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT,
		PH_TIME,
		PH_GAP
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [CH_W-1:0]  ch_q, ch_d, ch_next;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic             echo_bit;
	logic [CH_W:0]    ch_plus;
	uer_meas_t        nxt;

	always_comb begin
		echo_bit = 1'b0;
		for (int i = 0; i < ECHO_W; i++) begin
			if (ch_q == CH_W'(i)) begin
				echo_bit = echo_s1[i];
			end
		end
	end

	assign ch_plus = {1'b0, ch_q} + 1'b1;
	assign ch_next = (ch_plus >= (CH_W + 1)'(CHANNEL_COUNT)) ? '0 : ch_plus[CH_W-1:0];
	assign cnt_inc = cnt_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		ch_d        = ch_q;
		cnt_d       = cnt_q;
		nxt         = '0;
		nxt.kind    = RES_TIMEOUT;
		if (!run_enable) begin
			phase_d = PH_IDLE;
			ch_d    = '0;
			cnt_d   = '0;
		end else begin
			unique case (phase_q)
				PH_TRIG_LOW: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= CNT_W'(TRIG_LOW_TICKS)) begin
						phase_d = PH_TRIG_HIGH;
						cnt_d   = '0;
					end
				end
				PH_TRIG_HIGH: begin
					for (int i = 0; i < ECHO_W; i++) begin
						nxt.trig[i] = (ch_q == CH_W'(i));
					end
					cnt_d = cnt_inc;
					if (cnt_inc >= CNT_W'(TRIGGER_TICKS)) begin
						phase_d = PH_WAIT;
						cnt_d   = '0;
					end
				end
				PH_WAIT: begin
					if (echo_bit) begin
						phase_d = PH_TIME;
						cnt_d   = CNT_W'(1);
					end else if (cnt_q >= CNT_W'(ECHO_WAIT_TICKS)) begin
						nxt.ready = 1'b1;
						nxt.kind  = RES_TIMEOUT;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_TIME: begin
					if (!echo_bit) begin
						nxt.ready = 1'b1;
						nxt.kind  = (cnt_q < CNT_W'(MIN_ECHO_TICKS)) ? RES_FAULT : RES_PULSE;
						nxt.len   = cnt_q[LEN_W-1:0];
					end else if (cnt_q >= CNT_W'(MAX_ECHO_TICKS)) begin
						nxt.ready = 1'b1;
						nxt.kind  = RES_TIMEOUT;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_GAP: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= channel_gap_us) begin
						ch_d    = ch_next;
						phase_d = PH_TRIG_LOW;
						cnt_d   = '0;
					end
				end
				default: begin
					// idle, or a code with no meaning
					phase_d = PH_TRIG_LOW;
					cnt_d   = '0;
				end
			endcase
			if (nxt.ready) begin
				nxt.channel = ch_q;
				nxt.last    = (ch_q == CH_W'(CHANNEL_COUNT - 1));
				cnt_d       = '0;
				if (channel_gap_us == '0) begin
					ch_d    = ch_next;
					phase_d = PH_TRIG_LOW;
				end else begin
					phase_d = PH_GAP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ch_q     <= '0;
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				ch_q    <= ch_d;
				cnt_q   <= cnt_d;
			end
			if (load_s2) begin
				valid_s2 <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && fire) begin
			meas_s2 <= nxt;
		end
	end

`ifndef ASSERT_OFF
	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && nxt.ready |-> (phase_q == PH_WAIT || phase_q == PH_TIME))
		else $error("reading outside the echo phases");
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (nxt.trig != '0) |-> phase_q == PH_TRIG_HIGH)
		else $error("trigger driven outside the pulse");
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !run_enable |=> phase_q == PH_IDLE && ch_q == '0 && cnt_q == '0)
		else $error("disable did not abort");
`endif

endmodule

// File: rtl/core/uer_dist.sv
// Distance stage and output register: pulse length to centimetres, clamp, validity.
// Depends on uer_pkg.
module uer_dist import uer_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LIMIT_W-1:0] range_limit_cm,
	input  logic               valid_s2,
	input  uer_meas_t          meas_s2,
	output logic               load_s2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ECHO_W-1:0]  trigger_levels,
	output logic               reading_ready,
	output logic [CH_W-1:0]    reading_channel,
	output logic signed [DIST_W-1:0] range_cm,
	output logic               reading_valid,
	output logic               round_done
);

	logic [PROD_W-1:0]  prod;
	logic [CMP_W-1:0]   quot, limit_x, clamped;
	logic [DIST_W-1:0]  cm_val;
	logic               valid;
	logic               advance;

	assign advance = !out_valid || out_ready;
	assign load_s2 = advance;

	assign prod    = PROD_W'(meas_s2.len) * PROD_W'(CM_RECIP);
	assign quot    = CMP_W'(prod[DIV_SHIFT +: QUOT_W]);
	assign limit_x = CMP_W'(range_limit_cm);
	assign clamped = (quot > limit_x) ? limit_x : quot;

	always_comb begin
		cm_val = '0;
		valid  = 1'b0;
		if (meas_s2.ready) begin
			unique case (meas_s2.kind)
				RES_FAULT:   cm_val = '1;
				RES_PULSE:   cm_val = DIST_W'(clamped);
				default:     cm_val = DIST_W'(range_limit_cm);
			endcase
			// after the clamp only the lower bound can fail
			valid = (meas_s2.kind != RES_FAULT) && (cm_val >= DIST_W'(MIN_VALID_CM));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			trigger_levels  <= meas_s2.trig;
			reading_ready   <= meas_s2.ready;
			reading_channel <= meas_s2.ready ? meas_s2.channel : '0;
			range_cm        <= cm_val;
			reading_valid   <= valid;
			round_done      <= meas_s2.ready && meas_s2.last;
		end
	end

`ifndef ASSERT_OFF
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reading_ready |->
			range_cm == '0 && !reading_valid && !round_done && reading_channel == '0)
		else $error("reading fields set without a reading");
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reading_valid |->
			range_cm >= DIST_W'(MIN_VALID_CM) && range_cm <= DIST_W'(range_limit_cm))
		else $error("valid flag on a distance out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_cm))
		else $error("stalled word changed");
`endif

endmodule

// File: verif/ultrasonic_echo_ranger_top_tb.sv
// Self-checking testbench for ultrasonic_echo_ranger_top: tick words in, result words out.
// Directed table, then random measurements; expected words from the table or a predictor.
// Depends on uer_pkg and the ranger RTL.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top_tb;
	import uer_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 40_000_000;
	localparam int PHASES = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG_LOW,
		ST_TRIG_HIGH,
		ST_WAIT,
		ST_TIME,
		ST_GAP
	} seq_state_t;

	typedef struct packed {
		logic [ECHO_W-1:0]        trig;
		logic                     rdy;
		logic [CH_W-1:0]          ch;
		logic signed [DIST_W-1:0] cm;
		logic                     vld;
		logic                     last;
	} ranger_out_t;

	typedef struct {
		bit                wr;
		logic [IDX_W-1:0]  idx;
		logic [CFG_W-1:0]  data;
		int unsigned       reps;
		logic [ECHO_W-1:0] echo;
		bit                typed;
		ranger_out_t       want;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [ECHO_W-1:0]        echo_levels;
	logic                     out_valid;
	logic                     out_ready;
	logic [ECHO_W-1:0]        trigger_levels;
	logic                     reading_ready;
	logic [CH_W-1:0]          reading_channel;
	logic signed [DIST_W-1:0] range_cm;
	logic                     reading_valid;
	logic                     round_done;

	// predictor copy of the sequencer and its registers
	seq_state_t        st;
	logic [CH_W-1:0]   cur_ch;
	logic [CNT_W-1:0]  tick_cnt;
	logic              run_en;
	logic [LIMIT_W-1:0] limit_cm;
	logic [GAP_W-1:0]  gap_us;

	ranger_out_t reading_q[$];
	stim_row_t   stim_rows[$];

	int unsigned errors;
	int unsigned ticks;
	int unsigned directed_ticks;
	int unsigned rand_ticks;
	int unsigned readings;
	int unsigned faults;
	int unsigned at_limit;
	int unsigned words_seen;
	int unsigned cycles;
	bit          calm;
	bit          rx_hold;

	// shape of the next echo: low wait, then a pulse of pulse_plan ticks
	int unsigned wait_plan;
	int unsigned pulse_plan;
	bit          noisy_plan;

	int unsigned phase_limit [PHASES] = '{400, 2, 0, 1, 431, 511, 3, 300};
	int unsigned phase_gap   [PHASES] = '{0, 3, 1, 0, 17, 2, 0, 40};

	ultrasonic_echo_ranger_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.echo_levels     (echo_levels),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.trigger_levels  (trigger_levels),
		.reading_ready   (reading_ready),
		.reading_channel (reading_channel),
		.range_cm        (range_cm),
		.reading_valid   (reading_valid),
		.round_done      (round_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CH_W-1:0] next_channel(logic [CH_W-1:0] ch);
		int n;
		n = int'(ch) + 1;
		return (n >= CHANNEL_COUNT) ? '0 : CH_W'(n);
	endfunction

	function automatic ranger_out_t step_ranger(logic [ECHO_W-1:0] echo);
		ranger_out_t r;
		logic [CH_W-1:0] ch;
		logic hit;
		logic fault;
		int unsigned cm;
		r = '0;
		ch = cur_ch;
		hit = (ch < ECHO_W) ? echo[ch] : 1'b0;
		fault = 1'b0;
		cm = 0;
		if (!run_en) begin
			st = ST_IDLE;
			cur_ch = '0;
			tick_cnt = '0;
		end else begin
			case (st)
				ST_TRIG_LOW: begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= TRIG_LOW_TICKS) begin
						st = ST_TRIG_HIGH;
						tick_cnt = '0;
					end
				end
				ST_TRIG_HIGH: begin
					if (ch < ECHO_W)
						r.trig = ECHO_W'(1) << ch;
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= TRIGGER_TICKS) begin
						st = ST_WAIT;
						tick_cnt = '0;
					end
				end
				ST_WAIT: begin
					if (hit) begin
						st = ST_TIME;
						tick_cnt = CNT_W'(1);
					end else if (tick_cnt >= ECHO_WAIT_TICKS) begin
						r.rdy = 1'b1;
						cm = 32'(limit_cm);
					end else begin
						tick_cnt = tick_cnt + 1'b1;
					end
				end
				ST_TIME: begin
					if (!hit) begin
						r.rdy = 1'b1;
						if (tick_cnt < MIN_ECHO_TICKS) begin
							fault = 1'b1;
						end else begin
							cm = tick_cnt / CM_DIVISOR;
							if (cm > limit_cm)
								cm = 32'(limit_cm);
						end
					end else if (tick_cnt >= MAX_ECHO_TICKS) begin
						r.rdy = 1'b1;
						cm = 32'(limit_cm);
					end else begin
						tick_cnt = tick_cnt + 1'b1;
					end
				end
				ST_GAP: begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= gap_us) begin
						cur_ch = next_channel(cur_ch);
						st = ST_TRIG_LOW;
						tick_cnt = '0;
					end
				end
				default: begin
					st = ST_TRIG_LOW;
					tick_cnt = '0;
				end
			endcase
		end
		if (r.rdy) begin
			r.ch = ch;
			r.cm = fault ? -DIST_W'(1) : DIST_W'(cm);
			r.vld = !fault && cm >= MIN_VALID_CM && cm <= limit_cm;
			r.last = (ch == CHANNEL_COUNT - 1);
			readings++;
			if (fault)
				faults++;
			else if (cm == limit_cm)
				at_limit++;
			if (gap_us == 0) begin
				cur_ch = next_channel(cur_ch);
				st = ST_TRIG_LOW;
			end else begin
				st = ST_GAP;
			end
			tick_cnt = '0;
		end
		return r;
	endfunction

	function automatic ranger_out_t mk_reading(logic [ECHO_W-1:0] trig, logic rdy,
			logic [CH_W-1:0] ch, int cm, logic vld, logic last);
		ranger_out_t r;
		r.trig = trig;
		r.rdy = rdy;
		r.ch = ch;
		r.cm = DIST_W'(cm);
		r.vld = vld;
		r.last = last;
		return r;
	endfunction

	function automatic void add_ticks(int unsigned reps, logic [ECHO_W-1:0] echo);
		stim_row_t row;
		row = '{wr: 1'b0, idx: '0, data: '0, reps: reps, echo: echo, typed: 1'b0, want: '0};
		stim_rows.push_back(row);
	endfunction

	// the expectation applies to the last tick of the row
	function automatic void add_checked(int unsigned reps, logic [ECHO_W-1:0] echo,
			ranger_out_t want);
		stim_row_t row;
		row = '{wr: 1'b0, idx: '0, data: '0, reps: reps, echo: echo, typed: 1'b1, want: want};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		stim_row_t row;
		row = '{wr: 1'b1, idx: idx, data: data, reps: 0, echo: '0, typed: 1'b0, want: '0};
		stim_rows.push_back(row);
	endfunction

	function automatic int draw_idle();
		return calm ? 0 : $urandom_range(8, 0);
	endfunction

	function automatic void draw_plan();
		int unsigned sel;
		noisy_plan = ($urandom_range(99, 0) < 8);
		sel = $urandom_range(99, 0);
		if (sel < 80)
			wait_plan = $urandom_range(10, 0);
		else
			wait_plan = $urandom_range(40, 11);
		sel = $urandom_range(99, 0);
		if (sel < 40)
			pulse_plan = $urandom_range(99, 1);
		else if (sel < 55)
			pulse_plan = $urandom_range(101, 98);
		else if (sel < 95)
			pulse_plan = $urandom_range(200, 100);
		else
			pulse_plan = $urandom_range(350, 201);
	endfunction

	task automatic flag(string what, longint got, longint want);
		errors++;
		if (errors <= 40)
			$display("ERROR word %0d: %s got %0d expected %0d", words_seen, what, got, want);
	endtask

	// one tick word; the next call may keep in_valid high without a gap
	task automatic offer_tick(logic [ECHO_W-1:0] echo, bit typed, ranger_out_t want,
			output ranger_out_t got);
		int idle;
		idle = draw_idle();
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		echo_levels <= echo;
		do @(posedge clk); while (!in_ready);
		got = step_ranger(echo);
		reading_q.push_back(typed ? want : got);
		ticks++;
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (reading_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RUN_ENABLE:  run_en = data[0];
			CFG_RANGE_LIMIT: limit_cm = data[LIMIT_W-1:0];
			CFG_CHANNEL_GAP: gap_us = data[GAP_W-1:0];
			default: ;
		endcase
		repeat (2) @(posedge clk);
	endtask

	// cycle count, calm stretches and the long receiver hold-off
	initial begin
		cycles = 0;
		calm = 1'b0;
		rx_hold = 1'b0;
		forever begin
			@(posedge clk);
			cycles <= cycles + 1;
			if (cycles % 700 == 0)
				calm <= !calm;
			rx_hold <= (cycles >= 3000 && cycles < 3600);
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycles);
		$display("Mismatches found");
		$finish;
	end

	// result side
	initial begin
		int stall;
		bit hold;
		ranger_out_t w;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_idle();
			hold = rx_hold;
			if (stall > 0 || hold) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				if (hold)
					do @(posedge clk); while (rx_hold);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			words_seen++;
			if (reading_q.size() == 0) begin
				flag("word with nothing expected, distance", range_cm, 0);
			end else begin
				w = reading_q.pop_front();
				if (trigger_levels !== w.trig)
					flag("trigger_levels", trigger_levels, w.trig);
				if (reading_ready !== w.rdy)
					flag("reading_ready", reading_ready, w.rdy);
				if (reading_channel !== w.ch)
					flag("reading_channel", reading_channel, w.ch);
				if (range_cm !== w.cm)
					flag("range_cm", range_cm, w.cm);
				if (reading_valid !== w.vld)
					flag("reading_valid", reading_valid, w.vld);
				if (round_done !== w.last)
					flag("round_done", round_done, w.last);
			end
		end
	end

	// word side
	initial begin
		ranger_out_t got;
		ranger_out_t none;
		stim_row_t row;
		logic [ECHO_W-1:0] echo;
		logic lvl;
		int unsigned p;
		in_valid <= 1'b0;
		echo_levels <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		none = '0;
		errors = 0;
		ticks = 0;
		rand_ticks = 0;
		readings = 0;
		faults = 0;
		at_limit = 0;
		words_seen = 0;
		st = ST_IDLE;
		cur_ch = '0;
		tick_cnt = '0;
		run_en = 1'b0;
		limit_cm = LIMIT_W'(400);
		gap_us = GAP_W'(20000);

		// disabled after reset, then channel 0 short fault, channel 1 at the minimum
		// length, channel 2 at the smallest valid distance
		add_checked(3, 3'b111, none);
		add_write(CFG_CHANNEL_GAP, CFG_W'(0));
		add_write(CFG_RUN_ENABLE, CFG_W'(1));
		add_checked(3, 3'b111, none);
		add_checked(10, 3'b111, mk_reading(3'b001, 1'b0, 2'd0, 0, 1'b0, 1'b0));
		add_ticks(1, 3'b110);
		add_ticks(99, 3'b001);
		add_checked(1, 3'b110, mk_reading(3'b000, 1'b1, 2'd0, -1, 1'b0, 1'b0));
		add_checked(12, 3'b000, mk_reading(3'b010, 1'b0, 2'd0, 0, 1'b0, 1'b0));
		add_ticks(100, 3'b010);
		add_checked(1, 3'b101, mk_reading(3'b000, 1'b1, 2'd1, 1, 1'b0, 1'b0));
		add_checked(12, 3'b000, mk_reading(3'b100, 1'b0, 2'd0, 0, 1'b0, 1'b0));
		add_ticks(3, 3'b011);
		add_ticks(116, 3'b100);
		add_checked(1, 3'b011, mk_reading(3'b000, 1'b1, 2'd2, 2, 1'b1, 1'b1));
		// clamp to a small limit, then disable in the middle of a pulse
		add_write(CFG_RANGE_LIMIT, CFG_W'(3));
		add_ticks(12, 3'b000);
		add_ticks(232, 3'b001);
		add_checked(1, 3'b110, mk_reading(3'b000, 1'b1, 2'd0, 3, 1'b1, 1'b0));
		add_ticks(12, 3'b000);
		add_ticks(50, 3'b010);
		add_write(CFG_RUN_ENABLE, CFG_W'(0));
		add_checked(2, 3'b111, none);
		// widest limit and gap, then abort inside the gap
		add_write(CFG_RANGE_LIMIT, CFG_W'(511));
		add_write(CFG_CHANNEL_GAP, CFG_W'(20'hFFFFF));
		add_write(CFG_RUN_ENABLE, CFG_W'(1));
		add_checked(13, 3'b000, mk_reading(3'b001, 1'b0, 2'd0, 0, 1'b0, 1'b0));
		add_ticks(174, 3'b001);
		add_checked(1, 3'b110, mk_reading(3'b000, 1'b1, 2'd0, 3, 1'b1, 1'b0));
		add_checked(60, 3'b111, none);
		add_write(CFG_RUN_ENABLE, CFG_W'(0));
		add_checked(1, 3'b111, none);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.wr) begin
				write_reg(row.idx, row.data);
			end else begin
				for (int unsigned k = 0; k < row.reps; k++)
					offer_tick(row.echo, row.typed && k == row.reps - 1, row.want, got);
			end
		end
		directed_ticks = ticks;

		// random measurements with random content on the idle channels
		p = 0;
		while (p < PHASES || ticks < 1850) begin
			write_reg(CFG_RUN_ENABLE, CFG_W'(0));
			if (p < PHASES) begin
				write_reg(CFG_RANGE_LIMIT, CFG_W'(phase_limit[p]));
				write_reg(CFG_CHANNEL_GAP, CFG_W'(phase_gap[p]));
			end else begin
				write_reg(CFG_RANGE_LIMIT, CFG_W'($urandom_range(511, 0)));
				write_reg(CFG_CHANNEL_GAP, CFG_W'($urandom_range(40, 0)));
			end
			write_reg(CFG_RUN_ENABLE, CFG_W'(1));
			draw_plan();
			got = none;
			while (!got.rdy) begin
				echo = ECHO_W'($urandom_range(7, 0));
				lvl = echo[cur_ch];
				if (st == ST_WAIT)
					lvl = noisy_plan ? 1'($urandom_range(1, 0)) : (tick_cnt >= wait_plan);
				else if (st == ST_TIME)
					lvl = noisy_plan ? 1'($urandom_range(1, 0)) : (tick_cnt < pulse_plan);
				echo[cur_ch] = lvl;
				offer_tick(echo, 1'b0, none, got);
				rand_ticks++;
			end
			p++;
		end

		in_valid <= 1'b0;
		while (reading_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d tick words (%0d directed, %0d random) over %0d settings",
			ticks, directed_ticks, rand_ticks, p + 3);
		$display("Readings: %0d, short-echo faults %0d, at the range limit %0d",
			readings, faults, at_limit);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d field mismatches", errors);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
